@@ hdl/brl_pkg.sv @@
// Package for the backoff retry ledger: payload structs, codes, sizes and
// the backoff wait function. No dependencies.
`default_nettype none

package brl_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int ATTEMPT_CAP    = 6;
  localparam int BASE_WAIT      = 8;
  localparam int WAIT_CAP       = 512;

  localparam int AW         = (ATTEMPT_CAP > 0) ? $clog2(ATTEMPT_CAP + 1) : 1;
  localparam int CDW        = 16;
  localparam int SPAN_W     = 4;
  localparam int KEEP_W     = 31;
  localparam int CFG_W      = 32;
  localparam int BUDGET_W   = 7;
  localparam int OUTST_W    = 7;
  localparam int BUDGET_MAX = 64;
  localparam int SPAN_RESET = 8;
  localparam int KEEP_RESET = 4;

  localparam logic REG_SPAN = 1'b0;
  localparam logic REG_KEEP = 1'b1;

  typedef enum logic [1:0] {
    MODE_MARK  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_XS,
    S_XW,
    S_ZS,
    S_ZW,
    S_RD,
    S_UPD,
    S_EMIT,
    S_T1,
    S_T1D,
    S_T2,
    S_T2D
  } st_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic signed [31:0]   col_x;
    logic signed [31:0]   col_z;
    logic signed [31:0]   center_x;
    logic signed [31:0]   center_z;
    logic [BUDGET_W-1:0]  accept_budget;
  } in_item_t;

  typedef struct packed {
    logic                 submit_valid;
    logic signed [31:0]   submit_x;
    logic signed [31:0]   submit_z;
    logic                 cleared;
    logic [OUTST_W-1:0]   outstanding;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0]   x;
    logic signed [31:0]   z;
    logic [AW-1:0]        attempts;
    logic [CDW-1:0]       cooldown;
  } entry_t;

  function automatic logic [CDW-1:0] wait_of(input logic [AW-1:0] a);
    logic [63:0] w;
    w = 64'(BASE_WAIT) << a;
    if (w == 64'd0 || w > 64'(WAIT_CAP)) begin
      w = 64'(WAIT_CAP);
    end
    return w[CDW-1:0];
  endfunction

  function automatic int max_span(input int slots);
    int s;
    s = 15;
    while (s > 1 && s * s > slots) begin
      s = s - 1;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hdl/brl_modunit.sv @@
// Shared floor-mod unit: one remainder bit per cycle over a signed 32-bit value.
// Depends on brl_pkg for the span width.
`default_nettype none

module brl_modunit
  import brl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [31:0]       value,
  input  wire logic [SPAN_W-1:0]        divisor,
  output logic                          done,
  output logic [SPAN_W-1:0]             result
);

  logic                busy;
  logic                fin;
  logic [5:0]          cnt;
  logic [31:0]         mag;
  logic                neg;
  logic [SPAN_W-1:0]   rem;
  logic [SPAN_W-1:0]   rem_next;
  logic [SPAN_W-1:0]   div;
  logic [SPAN_W:0]     trial;
  logic [31:0]         mag_init;

  assign mag_init = value[31] ? (~value + 32'd1) : value;
  assign trial    = {rem, mag[31]};
  assign rem_next = (trial >= {1'b0, div}) ? SPAN_W'(trial - {1'b0, div})
                                           : trial[SPAN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd1) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag <= mag_init;
      neg <= value[31];
      rem <= '0;
      div <= divisor;
      cnt <= 6'd32;
    end else if (busy) begin
      rem <= rem_next;
      mag <= {mag[30:0], 1'b0};
      cnt <= cnt - 6'd1;
    end
  end

  assign done   = fin;
  assign result = (neg && rem != '0) ? SPAN_W'(div - rem) : rem;

endmodule

`default_nettype wire

@@ hdl/brl_store.sv @@
// Slot memory: coordinate, attempt count and cooldown per slot, one write
// port and one registered read port. Depends on brl_pkg for entry_t.
`default_nettype none

module brl_store
  import brl_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int IW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [IW-1:0]   wr_addr,
  input  wire entry_t          wr_entry,
  input  wire logic [IW-1:0]   rd_addr,
  output entry_t               rd_entry
);

  entry_t mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hdl/backoff_retry_ledger_top.sv @@
// Backoff retry ledger top level: sequencer, slot flags and configuration.
// Depends on brl_pkg, brl_modunit and brl_store.
`default_nettype none

// A mark or clear finds the slot position from two 32-step floor-mod runs
// (x, then z) in the one shared remainder unit, then reads and updates the
// slot memory. A tick runs two passes over the span*span window through the
// single memory read port: the first pass steps over free or in-flight slots
// and reads and updates each live slot, the second walks the slots up to the
// last submitted one and emits each submission, and output back-pressure can
// stall it. Results of a tick leave after the first pass, in slot order.
// Configuration writes are always taken; a span write frees every slot at
// once.
module backoff_retry_ledger_top
  import brl_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int IW        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW        = $clog2(SLOT_COUNT + 1);
  localparam int MAX_SPAN  = max_span(SLOT_COUNT);
  localparam int RESET_EFF = (SPAN_RESET > MAX_SPAN) ? MAX_SPAN : SPAN_RESET;

  st_t                  state, state_next;
  in_item_t             item, item_next;
  logic [CW-1:0]        idx, idx_next;
  logic [SPAN_W-1:0]    rx, rx_next;
  logic [6:0]           cnt, cnt_next;
  logic [6:0]           emitted, emitted_next;
  logic [6:0]           budget, budget_next;
  logic                 cleared, cleared_next;
  logic [SLOT_COUNT-1:0] live, live_next;
  logic [SLOT_COUNT-1:0] infl, infl_next;
  logic [SLOT_COUNT-1:0] sub, sub_next;
  logic [CW-1:0]        live_count, live_count_next;
  logic [SPAN_W-1:0]    span_eff, span_eff_next;
  logic [CW-1:0]        slot_total, slot_total_next;
  logic [KEEP_W-1:0]    keep, keep_next;

  logic                 ovalid;
  out_item_t            odata;
  logic                 out_load;
  out_item_t            out_word;
  logic                 out_free;

  logic                 mod_start;
  logic signed [31:0]   mod_value;
  logic                 mod_done;
  logic [SPAN_W-1:0]    mod_result;

  logic                 wr_en;
  entry_t               wr_entry;
  entry_t               rd;

  logic [IW-1:0]        i;
  logic [7:0]           slot8;
  logic                 match;
  logic [AW-1:0]        att;
  logic [CDW-1:0]       cd_dec;
  logic signed [32:0]   dx, dz, rad, nrad;
  logic                 in_box;
  logic [6:0]           bud_in;
  logic [SPAN_W-1:0]    span_in;
  logic [SPAN_W-1:0]    eff_in;
  logic [7:0]           total8;

  assign i        = idx[IW-1:0];
  assign out_free = !ovalid || out_ready;
  assign slot8    = {4'b0, mod_result} * {4'b0, span_eff} + {4'b0, rx};
  assign match    = live[i] && rd.x == item.col_x && rd.z == item.col_z;
  assign cd_dec   = (rd.cooldown == '0) ? '0 : CDW'(rd.cooldown - CDW'(1));
  assign rad      = $signed({2'b00, keep});
  assign nrad     = -rad;
  assign dx       = $signed({rd.x[31], rd.x}) - $signed({item.center_x[31], item.center_x});
  assign dz       = $signed({rd.z[31], rd.z}) - $signed({item.center_z[31], item.center_z});
  assign in_box   = dx <= rad && dx >= nrad && dz <= rad && dz >= nrad;
  assign bud_in   = (in_data.accept_budget > 7'(BUDGET_MAX)) ? 7'(BUDGET_MAX)
                                                             : in_data.accept_budget;
  assign span_in  = cfg_data[SPAN_W-1:0];
  assign eff_in   = (span_in == '0) ? SPAN_W'(1)
                  : (span_in > SPAN_W'(MAX_SPAN)) ? SPAN_W'(MAX_SPAN) : span_in;
  assign total8   = {4'b0, eff_in} * {4'b0, eff_in};
  assign mod_value = (state == S_XS) ? item.col_x : item.col_z;

  assign cfg_ready = 1'b1;

  brl_modunit u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .value   (mod_value),
    .divisor (span_eff),
    .done    (mod_done),
    .result  (mod_result)
  );

  brl_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .IW         (IW)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (i),
    .wr_entry (wr_entry),
    .rd_addr  (i),
    .rd_entry (rd)
  );

  always_comb begin
    state_next      = state;
    item_next       = item;
    idx_next        = idx;
    rx_next         = rx;
    cnt_next        = cnt;
    emitted_next    = emitted;
    budget_next     = budget;
    cleared_next    = cleared;
    live_next       = live;
    infl_next       = infl;
    sub_next        = sub;
    live_count_next = live_count;
    span_eff_next   = span_eff;
    slot_total_next = slot_total;
    keep_next       = keep;
    in_ready        = 1'b0;
    mod_start       = 1'b0;
    wr_en           = 1'b0;
    wr_entry        = rd;
    out_load        = 1'b0;
    out_word        = '0;
    att             = rd.attempts;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_next    = in_data;
          cleared_next = 1'b0;
          idx_next     = '0;
          cnt_next     = '0;
          emitted_next = '0;
          budget_next  = bud_in;
          unique case (in_data.mode)
            MODE_MARK:  state_next = S_XS;
            MODE_CLEAR: state_next = S_XS;
            MODE_TICK:  state_next = S_T1;
            MODE_NONE:  state_next = S_EMIT;
          endcase
        end
      end
      S_XS: begin
        mod_start  = 1'b1;
        state_next = S_XW;
      end
      S_XW: begin
        if (mod_done) begin
          rx_next    = mod_result;
          state_next = S_ZS;
        end
      end
      S_ZS: begin
        mod_start  = 1'b1;
        state_next = S_ZW;
      end
      S_ZW: begin
        if (mod_done) begin
          idx_next   = CW'(slot8);
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (item.mode == MODE_MARK) begin
          if (match) begin
            att = (rd.attempts < AW'(ATTEMPT_CAP)) ? AW'(rd.attempts + AW'(1))
                                                   : rd.attempts;
          end else begin
            att = '0;
            if (!live[i]) begin
              live_count_next = CW'(live_count + CW'(1));
            end
          end
          wr_en             = 1'b1;
          wr_entry.x        = item.col_x;
          wr_entry.z        = item.col_z;
          wr_entry.attempts = att;
          wr_entry.cooldown = wait_of(att);
          live_next[i]      = 1'b1;
          infl_next[i]      = 1'b0;
        end else if (match) begin
          live_next[i] = 1'b0;
          infl_next[i] = 1'b0;
          cleared_next = 1'b1;
          if (live_count != '0) begin
            live_count_next = CW'(live_count - CW'(1));
          end
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_word.cleared     = cleared;
          out_word.outstanding = OUTST_W'(live_count);
          out_word.last        = 1'b1;
          state_next           = S_IDLE;
        end
      end
      S_T1: begin
        if (idx == slot_total) begin
          idx_next   = '0;
          state_next = (cnt == '0) ? S_EMIT : S_T2;
        end else if (!live[i] || infl[i]) begin
          idx_next = CW'(idx + CW'(1));
        end else begin
          state_next = S_T1D;
        end
      end
      S_T1D: begin
        if (!in_box) begin
          live_next[i] = 1'b0;
          if (live_count != '0) begin
            live_count_next = CW'(live_count - CW'(1));
          end
        end else begin
          wr_en             = 1'b1;
          wr_entry.cooldown = cd_dec;
          if (cd_dec == '0 && cnt < budget) begin
            infl_next[i] = 1'b1;
            sub_next[i]  = 1'b1;
            cnt_next     = cnt + 7'd1;
          end
        end
        idx_next   = CW'(idx + CW'(1));
        state_next = S_T1;
      end
      S_T2: begin
        if (sub[i]) begin
          state_next = S_T2D;
        end else begin
          idx_next = CW'(idx + CW'(1));
        end
      end
      S_T2D: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_word.submit_valid = 1'b1;
          out_word.submit_x     = rd.x;
          out_word.submit_z     = rd.z;
          out_word.outstanding  = OUTST_W'(live_count);
          out_word.last         = (emitted + 7'd1 == cnt);
          sub_next[i]           = 1'b0;
          emitted_next          = emitted + 7'd1;
          idx_next              = CW'(idx + CW'(1));
          state_next            = (emitted + 7'd1 == cnt) ? S_IDLE : S_T2;
        end
      end
      default: state_next = S_IDLE;
    endcase

    priority if (cfg_valid && cfg_index == REG_SPAN) begin
      span_eff_next   = eff_in;
      slot_total_next = CW'(total8);
      live_next       = '0;
      infl_next       = '0;
      sub_next        = '0;
      live_count_next = '0;
    end else if (cfg_valid && cfg_index == REG_KEEP) begin
      keep_next = cfg_data[KEEP_W-1:0];
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live       <= '0;
      infl       <= '0;
      sub        <= '0;
      live_count <= '0;
      span_eff   <= SPAN_W'(RESET_EFF);
      slot_total <= CW'(RESET_EFF * RESET_EFF);
      keep       <= KEEP_W'(KEEP_RESET);
      ovalid     <= 1'b0;
    end else begin
      state      <= state_next;
      live       <= live_next;
      infl       <= infl_next;
      sub        <= sub_next;
      live_count <= live_count_next;
      span_eff   <= span_eff_next;
      slot_total <= slot_total_next;
      keep       <= keep_next;
      if (out_load) begin
        ovalid <= 1'b1;
      end else if (out_ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item    <= item_next;
    idx     <= idx_next;
    rx      <= rx_next;
    cnt     <= cnt_next;
    emitted <= emitted_next;
    budget  <= budget_next;
    cleared <= cleared_next;
    if (out_load) begin
      odata <= out_word;
    end
  end

  assign out_valid = ovalid;
  assign out_data  = odata;

endmodule

`default_nettype wire
